// ===== sv/rkeq_pkg.sv =====
package rkeq_pkg;

  localparam int CodeW = 10;
  localparam int ValueW = 8;
  localparam int TimeW = 32;
  localparam int MsW = 16;
  localparam int ActCodeW = 11;

  // action kinds
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_LONG  = 2'd2;

  // key values
  localparam logic signed [ValueW-1:0] VAL_RELEASE = 8'sd0;
  localparam logic signed [ValueW-1:0] VAL_PRESS   = 8'sd1;
  localparam logic signed [ValueW-1:0] VAL_REPEAT  = 8'sd2;

  // register indexes
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd0;
  localparam logic [1:0] REG_SCROLL_GAP   = 2'd1;
  localparam logic [1:0] REG_VERT_WHEEL   = 2'd2;
  localparam logic [1:0] REG_HORIZ_WHEEL  = 2'd3;

  typedef struct packed {
    logic [MsW-1:0]   repeat_delay_ms;
    logic [MsW-1:0]   scroll_gap_ms;
    logic [CodeW-1:0] vertical_wheel_code;
    logic [CodeW-1:0] horizontal_wheel_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          action_kind;
    logic [ActCodeW-1:0] action_code;
    logic                hold_active;
  } result_t;

endpackage

// ===== sv/remote_key_event_qualifier_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_is_sync, in_key_code, in_key_value,
//                                            in_time_ms, in_long_click_key
// out      output     out_valid / out_ready  out_action_kind, out_action_code,
//                                            out_hold_active
// cfg      input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item per cycle while in_ready is high; results go to the result register.
// The key state and the two 32-bit time compares update in the accept cycle.
// A two-entry output stage (result register plus skid register) lets the
// input take one more item while out_ready is low.
// Reset (synchronous) restores register defaults and clears valid and key state.
module remote_key_event_qualifier_unit
  import rkeq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_is_sync,
  input  logic [CodeW-1:0]         in_key_code,
  input  logic signed [ValueW-1:0] in_key_value,
  input  logic [TimeW-1:0]         in_time_ms,
  input  logic                     in_long_click_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_action_kind,
  output logic [ActCodeW-1:0]      out_action_code,
  output logic                     out_hold_active,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t    cfg_r;
  result_t new_res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    accept;
  logic    [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_delay_ms       <= MsW'(480);
      cfg_r.scroll_gap_ms         <= MsW'(100);
      cfg_r.vertical_wheel_code   <= CodeW'(8);
      cfg_r.horizontal_wheel_code <= CodeW'(6);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_REPEAT_DELAY: cfg_r.repeat_delay_ms       <= pwdata[MsW-1:0];
        REG_SCROLL_GAP:   cfg_r.scroll_gap_ms         <= pwdata[MsW-1:0];
        REG_VERT_WHEEL:   cfg_r.vertical_wheel_code   <= pwdata[CodeW-1:0];
        REG_HORIZ_WHEEL:  cfg_r.horizontal_wheel_code <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REPEAT_DELAY: prdata = {{(32-MsW){1'b0}}, cfg_r.repeat_delay_ms};
      REG_SCROLL_GAP:   prdata = {{(32-MsW){1'b0}}, cfg_r.scroll_gap_ms};
      REG_VERT_WHEEL:   prdata = {{(32-CodeW){1'b0}}, cfg_r.vertical_wheel_code};
      REG_HORIZ_WHEEL:  prdata = {{(32-CodeW){1'b0}}, cfg_r.horizontal_wheel_code};
      default:          prdata = '0;
    endcase
  end

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  rkeq_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .accept         (accept),
    .is_sync        (in_is_sync),
    .key_code       (in_key_code),
    .key_value      (in_key_value),
    .time_ms        (in_time_ms),
    .long_click_key (in_long_click_key),
    .result         (new_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      // advance: skid item first, else the fresh one
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : new_res;
    end else if (accept) begin
      skid_r <= new_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action_kind = out_r.action_kind;
  assign out_action_code = out_r.action_code;
  assign out_hold_active = out_r.hold_active;

endmodule

// ===== sv/rkeq_core.sv =====
module rkeq_core
  import rkeq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     accept,
  input  logic                     is_sync,
  input  logic [CodeW-1:0]         key_code,
  input  logic signed [ValueW-1:0] key_value,
  input  logic [TimeW-1:0]         time_ms,
  input  logic                     long_click_key,
  output result_t                  result
);

  logic                     awaiting_long_r, awaiting_long_nxt;
  logic                     holding_r, holding_nxt;
  logic                     suppress_hold_r, suppress_hold_nxt;
  logic [TimeW-1:0]         press_time_r, press_time_nxt;
  logic [TimeW-1:0]         scroll_time_r, scroll_time_nxt;
  logic [CodeW-1:0]         previous_code_r, previous_code_nxt;
  logic signed [ValueW-1:0] previous_value_r, previous_value_nxt;

  logic             cur_wheel, prev_wheel, allow, gap_ok, elapsed;
  logic [TimeW-1:0] scroll_dt, press_dt;

  assign cur_wheel  = (key_code == cfg.vertical_wheel_code) ||
                      (key_code == cfg.horizontal_wheel_code);
  assign prev_wheel = (previous_code_r == cfg.vertical_wheel_code) ||
                      (previous_code_r == cfg.horizontal_wheel_code);
  // a wheel step may not switch code or direction right after another wheel step
  assign allow      = ((previous_code_r == key_code) && (previous_value_r == key_value)) ||
                      !prev_wheel;
  assign scroll_dt  = time_ms - scroll_time_r;
  assign press_dt   = time_ms - press_time_r;
  assign gap_ok     = scroll_dt >= {{(TimeW-MsW){1'b0}}, cfg.scroll_gap_ms};
  assign elapsed    = press_dt >= {{(TimeW-MsW){1'b0}}, cfg.repeat_delay_ms};

  always_comb begin
    result             = '0;
    result.action_kind = ACT_NONE;
    awaiting_long_nxt  = awaiting_long_r;
    holding_nxt        = holding_r;
    suppress_hold_nxt  = suppress_hold_r;
    press_time_nxt     = press_time_r;
    scroll_time_nxt    = scroll_time_r;
    previous_code_nxt  = previous_code_r;
    previous_value_nxt = previous_value_r;
    if (!is_sync) begin
      previous_code_nxt  = key_code;
      previous_value_nxt = key_value;
      if (cur_wheel) begin
        if (gap_ok && allow) begin
          result.action_kind = ACT_PRESS;
          result.action_code = (key_value == VAL_PRESS) ?
                               {1'b0, key_code} + ActCodeW'(1) : {1'b0, key_code};
          scroll_time_nxt    = time_ms;
        end
      end else if (key_value == VAL_RELEASE) begin
        if (awaiting_long_r) begin
          result.action_kind = ACT_PRESS;
          result.action_code = {1'b0, key_code};
        end
        awaiting_long_nxt = 1'b0;
      end else if (key_value == VAL_PRESS) begin
        if (!long_click_key) begin
          result.action_kind = ACT_PRESS;
          result.action_code = {1'b0, key_code};
        end else begin
          awaiting_long_nxt = 1'b1;
        end
        press_time_nxt    = time_ms;
        holding_nxt       = 1'b0;
        // an older pending wait survives a plain press
        suppress_hold_nxt = long_click_key | awaiting_long_r;
      end else if (awaiting_long_r && (key_value == VAL_REPEAT) && elapsed) begin
        result.action_kind = ACT_LONG;
        result.action_code = {1'b0, key_code};
      end else if (!awaiting_long_r && elapsed && !suppress_hold_r) begin
        result.action_kind = ACT_PRESS;
        result.action_code = {1'b0, key_code};
        result.hold_active = 1'b1;
        holding_nxt        = 1'b1;
      end else begin
        holding_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_long_r  <= 1'b0;
      holding_r        <= 1'b0;
      suppress_hold_r  <= 1'b0;
      press_time_r     <= '0;
      scroll_time_r    <= '0;
      previous_code_r  <= '0;
      previous_value_r <= '0;
    end else if (accept) begin
      awaiting_long_r  <= awaiting_long_nxt;
      holding_r        <= holding_nxt;
      suppress_hold_r  <= suppress_hold_nxt;
      press_time_r     <= press_time_nxt;
      scroll_time_r    <= scroll_time_nxt;
      previous_code_r  <= previous_code_nxt;
      previous_value_r <= previous_value_nxt;
    end
  end

endmodule
